// ===== sv/lfsh_pkg.sv =====
// Package for the leader/follower sync handshake block.
// Holds field widths, event and mode codes, register reset values and shared types.
// No dependencies.
package lfsh_pkg;

  // Default width of stored timestamps.
  localparam int LFSH_TIME_BITS = 32;

  // Field widths.
  localparam int KIND_W  = 2;
  localparam int NOW_W   = 32;
  localparam int CODE_W  = 3;
  localparam int MODE_W  = 2;
  localparam int CFG_W   = 32;
  localparam int CADDR_W = 2;

  // Event kinds carried on the input channel.
  localparam logic [KIND_W-1:0] EV_STATE  = 2'd0;
  localparam logic [KIND_W-1:0] EV_STATUS = 2'd1;
  localparam logic [KIND_W-1:0] EV_SYNC   = 2'd2;
  localparam logic [KIND_W-1:0] EV_UPDATE = 2'd3;

  // Follower status codes.
  localparam logic [CODE_W-1:0] ST_IDLE     = 3'd0;
  localparam logic [CODE_W-1:0] ST_READY    = 3'd2;
  localparam logic [CODE_W-1:0] ST_TRACKING = 3'd3;
  localparam logic [CODE_W-1:0] ST_FAULT    = 3'd5;

  // Leader modes.
  localparam logic [MODE_W-1:0] LM_SYNC  = 2'd0;
  localparam logic [MODE_W-1:0] LM_READY = 2'd1;
  localparam logic [MODE_W-1:0] LM_TRACK = 2'd2;

  // Configuration register indexes.
  localparam logic [CADDR_W-1:0] REG_STATE_TIMEOUT  = 2'd0;
  localparam logic [CADDR_W-1:0] REG_STATUS_TIMEOUT = 2'd1;
  localparam logic [CADDR_W-1:0] REG_READY_DWELL    = 2'd2;

  // Configuration reset values.
  localparam logic [CFG_W-1:0] RST_STATE_TIMEOUT  = 32'd100000;
  localparam logic [CFG_W-1:0] RST_STATUS_TIMEOUT = 32'd100000;
  localparam logic [CFG_W-1:0] RST_READY_DWELL    = 32'd0;

  typedef struct packed {
    logic [CFG_W-1:0] state_timeout;
    logic [CFG_W-1:0] status_timeout;
    logic [CFG_W-1:0] ready_dwell;
  } lfsh_cfg_t;

  typedef struct packed {
    logic              start_pulse;
    logic              tracking_active;
    logic [MODE_W-1:0] leader_state;
  } lfsh_res_t;

endpackage

// ===== sv/lfsh_cfg.sv =====
// Configuration register file of the sync handshake block.
// Depends on lfsh_pkg for register indexes, widths and reset values.
module lfsh_cfg import lfsh_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]   cfg_wdata,
  output lfsh_cfg_t          cfg
);

  lfsh_cfg_t cfg_r;

  // Writes to an index past the last register are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.state_timeout  <= RST_STATE_TIMEOUT;
      cfg_r.status_timeout <= RST_STATUS_TIMEOUT;
      cfg_r.ready_dwell    <= RST_READY_DWELL;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_STATE_TIMEOUT:  cfg_r.state_timeout  <= cfg_wdata;
        REG_STATUS_TIMEOUT: cfg_r.status_timeout <= cfg_wdata;
        REG_READY_DWELL:    cfg_r.ready_dwell    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/lfsh_core.sv =====
// Handshake state and decision logic: heartbeat and status stamps, leader mode, ready timer.
// Depends on lfsh_pkg for codes and the configuration and result structs.
module lfsh_core import lfsh_pkg::*; #(
  parameter int TIME_BITS = LFSH_TIME_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 ev_go,
  input  logic [KIND_W-1:0]    ev_kind,
  input  logic [TIME_BITS-1:0] ev_now,
  input  logic [CODE_W-1:0]    ev_code,
  input  lfsh_cfg_t            cfg,
  output lfsh_res_t            res,
  output logic [MODE_W-1:0]    mode_q
);

  // Compare width wide enough for both time differences and 32-bit registers.
  localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

  logic [TIME_BITS-1:0] hb_time_r, hb_time_nxt;
  logic                 hb_valid_r, hb_valid_nxt;
  logic [TIME_BITS-1:0] rp_time_r, rp_time_nxt;
  logic                 rp_valid_r, rp_valid_nxt;
  logic [CODE_W-1:0]    fcode_r, fcode_nxt;
  logic [MODE_W-1:0]    mode_r, mode_nxt;
  logic [TIME_BITS-1:0] rdy_time_r, rdy_time_nxt;
  logic                 rdy_valid_r, rdy_valid_nxt;

  logic [TIME_BITS-1:0] hb_diff, rp_diff, rdy_diff;
  logic                 hb_ok, rp_ok, f_ready, dwell_done, started;

  assign hb_diff  = ev_now - hb_time_r;
  assign rp_diff  = ev_now - rp_time_r;
  assign rdy_diff = ev_now - rdy_time_r;

  // A stamp later than now means time went backwards: never fresh, never elapsed.
  assign hb_ok = hb_valid_r && (ev_now >= hb_time_r) &&
                 (CMP_W'(hb_diff) <= CMP_W'(cfg.state_timeout));
  assign rp_ok = rp_valid_r && (ev_now >= rp_time_r) &&
                 (CMP_W'(rp_diff) <= CMP_W'(cfg.status_timeout));
  assign f_ready = (fcode_r == ST_READY) || (fcode_r == ST_TRACKING);
  assign dwell_done = rdy_valid_r && (ev_now >= rdy_time_r) &&
                      (CMP_W'(rdy_diff) >= CMP_W'(cfg.ready_dwell));

  always_comb begin
    hb_time_nxt   = hb_time_r;
    hb_valid_nxt  = hb_valid_r;
    rp_time_nxt   = rp_time_r;
    rp_valid_nxt  = rp_valid_r;
    fcode_nxt     = fcode_r;
    mode_nxt      = mode_r;
    rdy_time_nxt  = rdy_time_r;
    rdy_valid_nxt = rdy_valid_r;
    started       = 1'b0;
    if (ev_go) begin
      case (ev_kind)
        EV_STATE: begin
          hb_time_nxt  = ev_now;
          hb_valid_nxt = 1'b1;
        end
        EV_STATUS: begin
          // Unrecognized codes leave both the code and its time untouched.
          if (ev_code inside {[ST_IDLE:ST_FAULT]}) begin
            fcode_nxt    = ev_code;
            rp_time_nxt  = ev_now;
            rp_valid_nxt = 1'b1;
          end
        end
        EV_SYNC: begin
          mode_nxt      = LM_SYNC;
          rdy_valid_nxt = 1'b0;
          rdy_time_nxt  = '0;
        end
        EV_UPDATE: begin
          if (!hb_ok || !rp_ok || !f_ready) begin
            mode_nxt      = LM_SYNC;
            rdy_valid_nxt = 1'b0;
            rdy_time_nxt  = '0;
          end else if (mode_r == LM_TRACK) begin
            mode_nxt = LM_TRACK;
          end else if (mode_r != LM_READY) begin
            mode_nxt      = LM_READY;
            rdy_time_nxt  = ev_now;
            rdy_valid_nxt = 1'b1;
          end else if (dwell_done) begin
            mode_nxt = LM_TRACK;
            started  = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hb_valid_r  <= 1'b0;
      rp_valid_r  <= 1'b0;
      fcode_r     <= ST_IDLE;
      mode_r      <= LM_SYNC;
      rdy_valid_r <= 1'b0;
    end else begin
      hb_valid_r  <= hb_valid_nxt;
      rp_valid_r  <= rp_valid_nxt;
      fcode_r     <= fcode_nxt;
      mode_r      <= mode_nxt;
      rdy_valid_r <= rdy_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hb_time_r  <= hb_time_nxt;
    rp_time_r  <= rp_time_nxt;
    rdy_time_r <= rdy_time_nxt;
  end

  assign res.leader_state    = mode_nxt;
  assign res.tracking_active = (mode_nxt == LM_TRACK);
  assign res.start_pulse     = started;
  assign mode_q              = mode_r;

endmodule

// ===== sv/leader_follower_sync_handshake_top.sv =====
// Top level of the leader side of a leader/follower sync handshake.
// Depends on lfsh_pkg, lfsh_cfg and lfsh_core.
//
// This block plays the leader in a sync handshake with a follower. Each input transaction
// is one event: tuser carries the kind (follower state heartbeat, status report, sync
// request or update tick) and tdata carries a tick timestamp and a follower status code.
// Heartbeats and status reports only update stored stamps and status; a sync request drops the leader
// back to the sync mode. Only an update tick produces an output transaction, holding the
// leader mode, a tracking flag and a one-shot flag that marks the update that entered
// tracking. An update checks that both stamps are no older than their timeouts and that
// the follower reports ready or tracking; if so the leader moves to ready and, once
// ready_dwell ticks have passed, to tracking. A timestamp older than a stored stamp counts
// as stale. Accepted events go into an input register, and the decision logic lies between it
// and the output register, so the block takes one transaction per cycle while the input side
// does not stall; an update tick goes from the input register through the decision logic into
// the output register once that register has room. The input side stalls only while an update tick
// waits in the input register behind an output transaction that has not been taken.
// Timestamps are stored in TIME_BITS bits; the incoming time is reduced to that width.
// Configuration writes are meant to happen only while no transaction is in flight.
module leader_follower_sync_handshake_top import lfsh_pkg::*; #(
  parameter int TIME_BITS = LFSH_TIME_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel.
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [39:0]        in_tdata,   // [31:0] now, [34:32] status_code, rest zero
  input  logic [KIND_W-1:0]  in_tuser,   // [1:0] kind
  // Result channel.
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,  // [1:0] leader_state, [2] tracking_active,
                                         // [3] start_pulse, rest zero
  // Configuration write port.
  input  logic               cfg_we,
  input  logic [CADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  lfsh_cfg_t cfg;
  lfsh_res_t res;
  logic [MODE_W-1:0] mode_q;

  // Input register.
  logic                 s1_valid_r;
  logic [KIND_W-1:0]    s1_kind_r;
  logic [TIME_BITS-1:0] s1_now_r;
  logic [CODE_W-1:0]    s1_code_r;
  logic                 s1_go;
  logic                 s1_upd;

  // Output register.
  logic      out_valid_r;
  lfsh_res_t out_res_r;

  // Only an update tick needs room in the output register; other events always drain.
  assign s1_upd    = (s1_kind_r == EV_UPDATE);
  assign s1_go     = s1_valid_r && (!s1_upd || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_kind_r <= in_tuser;
      s1_now_r  <= TIME_BITS'(in_tdata[NOW_W-1:0]);
      s1_code_r <= in_tdata[NOW_W+CODE_W-1:NOW_W];
    end
  end

  lfsh_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lfsh_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .ev_go   (s1_go),
    .ev_kind (s1_kind_r),
    .ev_now  (s1_now_r),
    .ev_code (s1_code_r),
    .cfg     (cfg),
    .res     (res),
    .mode_q  (mode_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_upd) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_upd) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_res_r.start_pulse, out_res_r.tracking_active,
                       out_res_r.leader_state};

  // A new output transaction only appears after an update tick left the input register.
  a_out_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_go && s1_upd))
    else $error("output became valid without an update tick");

  // The input side stalls only behind an update waiting on a full, stalled output.
  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && s1_upd && out_valid_r && !out_tready))
    else $error("input stalled without a blocked update");

  // A sync request always leaves the leader in the sync mode.
  a_sync_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && (s1_kind_r == EV_SYNC)) |=> (mode_q == LM_SYNC))
    else $error("sync request did not drop the leader");

  // Tracking can only start from the ready mode.
  a_start_from_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_upd && res.start_pulse) |-> (mode_q == LM_READY))
    else $error("tracking started from a mode other than ready");

endmodule

// ===== tb/tb_leader_follower_sync_handshake_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for leader_follower_sync_handshake_top.
// Depends on lfsh_pkg and the block's RTL. The predictor of the leader decision is kept here.
module tb_leader_follower_sync_handshake_top;
  import lfsh_pkg::*;

  // The configuration port also decodes this index, which maps to no register.
  localparam logic [CADDR_W-1:0] REG_UNMAPPED = 2'd3;

  // One event as the sender presents it on the input channel.
  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [NOW_W-1:0]  now;
    logic [CODE_W-1:0] code;
  } sync_event_t;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [39:0]        in_tdata;   // [31:0] now, [34:32] status_code, rest zero
  logic [KIND_W-1:0]  in_tuser;   // [1:0] kind
  logic               out_tvalid;
  logic               out_tready;
  logic [7:0]         out_tdata;  // [1:0] leader_state, [2] tracking_active,
                                  // [3] start_pulse, rest zero
  logic               cfg_we;
  logic [CADDR_W-1:0] cfg_addr;
  logic [CFG_W-1:0]   cfg_wdata;

  leader_follower_sync_handshake_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // A 10 ns clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Events waiting to be sent, and the leader reports that the predictor expects back.
  sync_event_t event_queue[$];
  lfsh_res_t   expected_reports[$];
  int          mismatch_count = 0;

  // Handshake bookkeeping between the rising-edge sampler and the falling-edge drivers.
  bit          in_taken = 1'b0;
  bit          out_taken = 1'b0;
  int          send_gap = 0;
  int          send_max = 0;
  int          recv_stall = 0;
  int          recv_max = 0;
  bit          park_req = 1'b0;
  int          park_left = 0;
  sync_event_t next_event;

  // Predictor state: the leader's own view of the follower and its configuration.
  logic [CFG_W-1:0]  lim_heartbeat;
  logic [CFG_W-1:0]  lim_report;
  logic [CFG_W-1:0]  dwell_ticks;
  logic [NOW_W-1:0]  heartbeat_stamp;
  bit                heartbeat_seen;
  logic [NOW_W-1:0]  report_stamp;
  bit                report_seen;
  logic [CODE_W-1:0] follower_status;
  logic [MODE_W-1:0] leader_mode;
  logic [NOW_W-1:0]  ready_since;
  bit                ready_armed;

  // Stimulus generator's running clock.
  logic [NOW_W-1:0]  gen_now = '0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // A stamp counts as fresh only if it was seen, lies not in the future, and is young enough.
  function automatic bit stamp_fresh(input bit seen, input logic [NOW_W-1:0] stamp,
                                     input logic [NOW_W-1:0] now, input logic [CFG_W-1:0] limit);
    logic [NOW_W-1:0] age;
    age = now - stamp;
    return seen && (now >= stamp) && (age <= limit);
  endfunction

  // Applies one event to the leader's state. Only an update tick yields a report.
  task automatic leader_decide(input sync_event_t ev, output bit has_report,
                               output lfsh_res_t report);
    logic [NOW_W-1:0] waited;
    bit               started;
    has_report = 1'b0;
    started    = 1'b0;
    report     = '0;
    case (ev.kind)
      EV_STATE: begin
        heartbeat_stamp = ev.now;
        heartbeat_seen  = 1'b1;
      end
      EV_STATUS: begin
        // Codes past fault are unknown and leave the stored report untouched.
        if (ev.code <= ST_FAULT) begin
          follower_status = ev.code;
          report_stamp    = ev.now;
          report_seen     = 1'b1;
        end
      end
      EV_SYNC: begin
        leader_mode = LM_SYNC;
        ready_armed = 1'b0;
        ready_since = '0;
      end
      default: begin
        waited = ev.now - ready_since;
        if (!stamp_fresh(heartbeat_seen, heartbeat_stamp, ev.now, lim_heartbeat) ||
            !stamp_fresh(report_seen, report_stamp, ev.now, lim_report) ||
            !(follower_status == ST_READY || follower_status == ST_TRACKING)) begin
          leader_mode = LM_SYNC;
          ready_armed = 1'b0;
          ready_since = '0;
        end else if (leader_mode == LM_TRACK) begin
          // Tracking holds as long as every check passes.
        end else if (leader_mode != LM_READY) begin
          leader_mode = LM_READY;
          ready_since = ev.now;
          ready_armed = 1'b1;
        end else if (ready_armed && ev.now >= ready_since && waited >= dwell_ticks) begin
          leader_mode = LM_TRACK;
          started     = 1'b1;
        end
        has_report              = 1'b1;
        report.leader_state     = leader_mode;
        report.tracking_active  = (leader_mode == LM_TRACK);
        report.start_pulse      = started;
      end
    endcase
  endtask

  // Rising edge: every transaction on either channel is seen here. Results are checked
  // before the accepted event is applied; a report leaves the block only after its event
  // has been accepted and passed through the input register, so the order does not matter,
  // but it keeps the expectation queue in the order the block produces reports.
  always @(posedge clk) begin
    lfsh_res_t want;
    lfsh_res_t got;
    bit        has_report;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        out_taken = 1'b1;
        got = lfsh_res_t'(out_tdata[3:0]);
        if (expected_reports.size() == 0) begin
          report_mismatch("report with none expected", 32'(out_tdata), 0);
        end else begin
          want = expected_reports.pop_front();
          if (got.leader_state != want.leader_state)
            report_mismatch("leader_state", 32'(got.leader_state), 32'(want.leader_state));
          if (got.tracking_active != want.tracking_active)
            report_mismatch("tracking_active", 32'(got.tracking_active),
                            32'(want.tracking_active));
          if (got.start_pulse != want.start_pulse)
            report_mismatch("start_pulse", 32'(got.start_pulse), 32'(want.start_pulse));
        end
      end
      if (in_tvalid && in_tready) begin
        in_taken = 1'b1;
        next_event.kind = in_tuser;
        next_event.now  = in_tdata[31:0];
        next_event.code = in_tdata[34:32];
        leader_decide(next_event, has_report, want);
        if (has_report)
          expected_reports.push_back(want);
      end
    end
  end

  // Long receiver hold-off, counted in its own process. It runs on the rising edge so
  // that the receiver, which reads it on the falling edge, never races with it.
  always @(posedge clk) begin
    if (park_req) begin
      park_req  = 1'b0;
      park_left = 300;
    end else if (park_left > 0) begin
      park_left--;
    end
  end

  // Sender: presents the next queued event after a random gap. A presented event stays
  // on the bus until its transaction completes; valid stays high across back-to-back
  // events, so it gets at most one assignment per falling edge.
  always @(negedge clk) begin
    sync_event_t ev;
    if (rst_n && (!in_tvalid || in_taken)) begin
      in_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (event_queue.size() > 0) begin
        ev = event_queue.pop_front();
        in_tdata  <= {5'b0, ev.code, ev.now};
        in_tuser  <= ev.kind;
        in_tvalid <= 1'b1;
        send_gap = $urandom_range(0, send_max);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: after each taken report it stalls for a random number of cycles, and it
  // drops ready for the whole hold-off when one is running.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        out_taken  = 1'b0;
        recv_stall = $urandom_range(0, recv_max);
      end else if (recv_stall > 0) begin
        recv_stall--;
      end
      out_tready <= (recv_stall == 0) && (park_left == 0);
    end
  end

  task automatic push_event(input logic [KIND_W-1:0] kind, input logic [NOW_W-1:0] now,
                            input logic [CODE_W-1:0] code);
    sync_event_t ev;
    ev.kind = kind;
    ev.now  = now;
    ev.code = code;
    event_queue.push_back(ev);
  endtask

  // A value a couple of ticks either side of a limit, so both sides of each compare occur.
  function automatic logic [NOW_W-1:0] around(input logic [NOW_W-1:0] v);
    return v + $urandom_range(0, 4) - 2;
  endfunction

  function automatic logic [NOW_W-1:0] pick_step();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return $urandom_range(1, 8);
      2:       return around(dwell_ticks);
      3:       return around(lim_heartbeat);
      4:       return around(lim_report);
      5:       return $urandom_range(0, 64);
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  // Mostly well-formed handshakes (heartbeat, status, a run of updates) with random
  // timing, and in about a fifth of the draws a single noise event: random kinds, codes and times,
  // including time running backwards and times anywhere in the 32-bit range.
  task automatic add_random_events(input int count);
    int               added;
    int               k;
    logic [CODE_W-1:0] st;
    logic [NOW_W-1:0]  t;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 9) < 8) begin
        gen_now += pick_step();
        push_event(EV_STATE, gen_now, 3'($urandom_range(0, 7)));
        gen_now += $urandom_range(0, 3);
        if ($urandom_range(0, 4) != 0)
          st = $urandom_range(0, 1) ? ST_READY : ST_TRACKING;
        else
          st = 3'($urandom_range(0, 7));
        push_event(EV_STATUS, gen_now, st);
        added += 2;
        k = $urandom_range(1, 5);
        repeat (k) begin
          if ($urandom_range(0, 11) == 0) begin
            push_event(EV_SYNC, gen_now, 3'($urandom_range(0, 7)));
            added++;
          end
          gen_now += pick_step();
          push_event(EV_UPDATE, gen_now, 3'($urandom_range(0, 7)));
          added++;
        end
      end else begin
        case ($urandom_range(0, 3))
          0:       t = $urandom();
          1:       t = gen_now - $urandom_range(1, 50);
          default: t = gen_now + $urandom_range(0, 20);
        endcase
        push_event(2'($urandom_range(0, 3)), t, 3'($urandom_range(0, 7)));
        added++;
      end
    end
  endtask

  // Waits until every queued event has been sent and every report has come back, then
  // waits on so that events with no report have also left the block.
  task automatic wait_idle();
    while (event_queue.size() != 0 || in_tvalid || expected_reports.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Register writes happen only while the block is idle; the predictor takes the new
  // value at once. An index past the register list is decoded and must be ignored.
  task automatic write_reg(input logic [CADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_STATE_TIMEOUT:  lim_heartbeat = val;
      REG_STATUS_TIMEOUT: lim_report    = val;
      REG_READY_DWELL:    dwell_ticks   = val;
      default:            ;
    endcase
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] hb_limit, input logic [CFG_W-1:0] rp_limit,
                           input logic [CFG_W-1:0] dwell, input int count, input bit park);
    wait_idle();
    write_reg(REG_STATE_TIMEOUT, hb_limit);
    write_reg(REG_STATUS_TIMEOUT, rp_limit);
    write_reg(REG_READY_DWELL, dwell);
    if ($urandom_range(0, 2) == 0)
      write_reg(REG_UNMAPPED, $urandom());
    cfg_we <= 1'b0;
    // Idling comes in stretches: each phase either runs flat out or idles at random.
    send_max = $urandom_range(0, 1) ? 15 : 0;
    recv_max = $urandom_range(0, 1) ? 15 : 0;
    if (park) begin
      // The sender keeps offering events at full rate while the receiver holds off,
      // so the output register and the input register fill and in_tready drops.
      send_max = 0;
      recv_max = 0;
      park_req = 1'b1;
    end
    add_random_events(count);
  endtask

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    // Every input known from time zero, with reset asserted.
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= EV_STATE;
    out_tready <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_addr   <= REG_STATE_TIMEOUT;
    cfg_wdata  <= '0;

    lim_heartbeat   = RST_STATE_TIMEOUT;
    lim_report      = RST_STATUS_TIMEOUT;
    dwell_ticks     = RST_READY_DWELL;
    heartbeat_stamp = '0;
    heartbeat_seen  = 1'b0;
    report_stamp    = '0;
    report_seen     = 1'b0;
    follower_status = ST_IDLE;
    leader_mode     = LM_SYNC;
    ready_since     = '0;
    ready_armed     = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed events under the reset configuration: zero dwell, 100000-tick timeouts.
    // An update before any heartbeat must stay in the sync mode.
    push_event(EV_UPDATE, 32'd5, 3'd7);
    // Ready follower: the first update enters ready, the next one tracking at once.
    push_event(EV_STATE, 32'd10, 3'd6);
    push_event(EV_STATUS, 32'd10, ST_READY);
    push_event(EV_UPDATE, 32'd10, 3'd0);
    push_event(EV_UPDATE, 32'd10, 3'd5);
    push_event(EV_UPDATE, 32'd20, 3'd1);
    // Unknown status codes must not replace the stored ready status.
    push_event(EV_STATUS, 32'd30, 3'd7);
    push_event(EV_STATUS, 32'd31, 3'd6);
    push_event(EV_UPDATE, 32'd100, 3'd2);
    // A tracking follower counts as ready; a sync request restarts the climb.
    push_event(EV_STATUS, 32'd110, ST_TRACKING);
    push_event(EV_SYNC, 32'd115, 3'd5);
    push_event(EV_UPDATE, 32'd120, 3'd3);
    push_event(EV_UPDATE, 32'd121, 3'd4);
    // Lost, fault, idle and aligning each drop the leader.
    push_event(EV_STATUS, 32'd130, 3'd4);
    push_event(EV_UPDATE, 32'd131, 3'd0);
    push_event(EV_STATUS, 32'd140, ST_FAULT);
    push_event(EV_UPDATE, 32'd141, 3'd0);
    push_event(EV_STATUS, 32'd150, ST_IDLE);
    push_event(EV_UPDATE, 32'd151, 3'd0);
    push_event(EV_STATUS, 32'd160, 3'd1);
    push_event(EV_UPDATE, 32'd161, 3'd0);
    // Top of the time range, then time running backwards, which makes every stamp stale.
    push_event(EV_STATE, 32'hFFFF_FFFF, 3'd7);
    push_event(EV_STATUS, 32'hFFFF_FFFF, ST_READY);
    push_event(EV_UPDATE, 32'hFFFF_FFFF, 3'd7);
    push_event(EV_UPDATE, 32'd0, 3'd0);

    // Random phases across several settings, the extremes among them.
    run_phase(32'd100, 32'd100, 32'd0, 150, 1'b0);
    run_phase(32'd1, 32'd1, 32'd1, 150, 1'b0);
    run_phase(32'd0, 32'd0, 32'd5, 150, 1'b0);
    run_phase($urandom_range(50, 5000), $urandom_range(50, 5000), $urandom_range(0, 200),
              160, 1'b1);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 150, 1'b0);
    run_phase(32'd1000, 32'd30, 32'd16, 160, 1'b0);
    run_phase(32'hFFFF_FFFF, 32'd1000, 32'd0, 150, 1'b0);
    run_phase(32'd200, 32'hFFFF_FFFF, 32'd50, 150, 1'b0);

    wait_idle();
    repeat (6) @(negedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
